// File: hw/rtl/stl_pkg.sv
// stl_pkg: token kinds, lexer modes and the queue entry type for the token lexer
// used by stl_front, stl_back and script_token_lexer_top; no dependencies
package stl_pkg;

	typedef enum logic [2:0] {
		M_IDLE  = 3'd0,
		M_NUM   = 3'd1,
		M_WORD  = 3'd2,
		M_EQ1   = 3'd3,
		M_EQ2   = 3'd4,
		M_BANG1 = 3'd5,
		M_BANG2 = 3'd6
	} lex_mode_t;

	localparam logic [5:0] K_EOF       = 6'd0;
	localparam logic [5:0] K_ILLEGAL   = 6'd1;
	localparam logic [5:0] K_NUMBER    = 6'd2;
	localparam logic [5:0] K_IDENT     = 6'd3;
	localparam logic [5:0] K_ASSIGN    = 6'd4;
	localparam logic [5:0] K_BANG      = 6'd15;
	localparam logic [5:0] K_WEAK_EQ   = 6'd21;
	localparam logic [5:0] K_WEAK_NE   = 6'd22;
	localparam logic [5:0] K_STRONG_EQ = 6'd23;
	localparam logic [5:0] K_STRONG_NE = 6'd24;
	localparam logic [5:0] K_KW_BASE   = 6'd25;

	localparam int KW_COUNT = 9;
	localparam int KW_MAX   = 8;

	// keyword text, first character in the low byte
	typedef logic [KW_MAX*8-1:0] kw_text_t;

	function automatic kw_text_t kw_text(input int k);
		kw_text_t t;
		t = '0;
		case (k)
			0: t = {"noitcnuf"};
			1: t = {40'd0, "tel"};
			2: t = {24'd0, "tsnoc"};
			3: t = {40'd0, "rav"};
			4: t = {32'd0, "eurt"};
			5: t = {24'd0, "eslaf"};
			6: t = {48'd0, "fi"};
			7: t = {32'd0, "esle"};
			default: t = {16'd0, "nruter"};
		endcase
		return t;
	endfunction

	function automatic logic [3:0] kw_len(input int k);
		logic [3:0] l;
		case (k)
			0: l = 4'd8;
			1: l = 4'd3;
			2: l = 4'd5;
			3: l = 4'd3;
			4: l = 4'd4;
			5: l = 4'd5;
			6: l = 4'd2;
			7: l = 4'd4;
			default: l = 4'd6;
		endcase
		return l;
	endfunction

	// token entry passed from the front part to the back part
	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic        last;
	} token_t;

endpackage

// File: hw/rtl/stl_front.sv
// stl_front: classifies each byte, tracks the pending token, emits up to two tokens
// depends on stl_pkg
module stl_front #(
	parameter int OFFSET_BITS   = 16,
	parameter int KEYWORD_CHARS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              action,
	input  logic [7:0]        char_byte,
	output logic [1:0]        tok_n,
	output stl_pkg::token_t   tok0,
	output stl_pkg::token_t   tok1
);

	localparam logic [OFFSET_BITS-1:0] LEN_MAX = {OFFSET_BITS{1'b1}};
	localparam int PIDX = $clog2(KEYWORD_CHARS);

	stl_pkg::lex_mode_t       mode_q;
	logic [OFFSET_BITS-1:0]   offset_q;
	logic [OFFSET_BITS-1:0]   pstart_q;
	logic [OFFSET_BITS-1:0]   plen_q;
	logic [7:0]               prefix_q [KEYWORD_CHARS];

	stl_pkg::lex_mode_t       mode_d;
	logic [OFFSET_BITS-1:0]   pstart_d;
	logic [OFFSET_BITS-1:0]   plen_d;
	logic [5:0]               word_kind;
	logic [5:0]               flush_kind;
	logic                     flush_has;
	logic                     is_digit, is_letter, is_space;
	logic [5:0]               op_kind;
	logic                     pre_wr, pre_clr;

	// byte classes
	always_comb begin
		is_digit  = char_byte >= "0" && char_byte <= "9";
		is_letter = (char_byte >= "a" && char_byte <= "z") ||
			(char_byte >= "A" && char_byte <= "Z");
		is_space  = char_byte == " " || char_byte == 8'h09 || char_byte == 8'h0d ||
			char_byte == 8'h0a;
		case (char_byte)
			"+": op_kind = 6'd5;
			"(": op_kind = 6'd6;
			")": op_kind = 6'd7;
			"{": op_kind = 6'd8;
			"}": op_kind = 6'd9;
			"[": op_kind = 6'd10;
			"]": op_kind = 6'd11;
			",": op_kind = 6'd12;
			";": op_kind = 6'd13;
			"-": op_kind = 6'd14;
			"/": op_kind = 6'd16;
			"*": op_kind = 6'd17;
			"%": op_kind = 6'd18;
			"<": op_kind = 6'd19;
			">": op_kind = 6'd20;
			default: op_kind = stl_pkg::K_ILLEGAL;
		endcase
	end

	// parallel keyword compare against the stored prefix
	always_comb begin
		logic hit;
		stl_pkg::kw_text_t txt;
		word_kind = stl_pkg::K_IDENT;
		for (int k = stl_pkg::KW_COUNT - 1; k >= 0; k--) begin
			txt = stl_pkg::kw_text(k);
			hit = plen_q == OFFSET_BITS'(stl_pkg::kw_len(k));
			for (int i = 0; i < stl_pkg::KW_MAX; i++) begin
				if (i < int'(stl_pkg::kw_len(k)))
					hit = hit && prefix_q[i] == txt[i*8 +: 8];
			end
			if (hit)
				word_kind = stl_pkg::K_KW_BASE + 6'(k);
		end
	end

	// kind of the pending token when it is flushed
	always_comb begin
		flush_has = 1'b1;
		unique case (mode_q)
			stl_pkg::M_NUM:   flush_kind = stl_pkg::K_NUMBER;
			stl_pkg::M_WORD:  flush_kind = word_kind;
			stl_pkg::M_EQ1:   flush_kind = stl_pkg::K_ASSIGN;
			stl_pkg::M_EQ2:   flush_kind = stl_pkg::K_WEAK_EQ;
			stl_pkg::M_BANG1: flush_kind = stl_pkg::K_BANG;
			stl_pkg::M_BANG2: flush_kind = stl_pkg::K_WEAK_NE;
			default: begin
				flush_kind = stl_pkg::K_EOF;
				flush_has  = 1'b0;
			end
		endcase
	end

	// next state and emitted tokens
	always_comb begin
		stl_pkg::token_t ft;
		ft.kind   = flush_kind;
		ft.start  = 16'(pstart_q);
		ft.length = 16'(plen_q);
		ft.last   = 1'b0;
		mode_d   = mode_q;
		pstart_d = pstart_q;
		plen_d   = plen_q;
		pre_wr   = 1'b0;
		pre_clr  = 1'b0;
		tok_n    = 2'd0;
		tok0     = ft;
		tok1     = ft;
		if (action) begin
			tok1.kind   = stl_pkg::K_EOF;
			tok1.start  = 16'(offset_q);
			tok1.length = 16'd0;
			tok1.last   = 1'b1;
			if (flush_has) begin
				tok_n = 2'd2;
			end else begin
				tok_n = 2'd1;
				tok0  = tok1;
			end
			mode_d   = stl_pkg::M_IDLE;
			pstart_d = '0;
			plen_d   = '0;
			pre_clr  = 1'b1;
		end else if ((mode_q == stl_pkg::M_EQ1 || mode_q == stl_pkg::M_BANG1) &&
				char_byte == "=") begin
			mode_d = (mode_q == stl_pkg::M_EQ1) ? stl_pkg::M_EQ2 : stl_pkg::M_BANG2;
			plen_d = OFFSET_BITS'(2);
		end else if ((mode_q == stl_pkg::M_EQ2 || mode_q == stl_pkg::M_BANG2) &&
				char_byte == "=") begin
			tok_n       = 2'd1;
			tok0.kind   = (mode_q == stl_pkg::M_EQ2) ? stl_pkg::K_STRONG_EQ :
				stl_pkg::K_STRONG_NE;
			tok0.length = 16'd3;
			tok0.last   = 1'b1;
			mode_d      = stl_pkg::M_IDLE;
			plen_d      = '0;
		end else if (mode_q == stl_pkg::M_NUM && is_digit) begin
			if (plen_q != LEN_MAX)
				plen_d = plen_q + 1'b1;
		end else if (mode_q == stl_pkg::M_WORD && is_letter) begin
			pre_wr = plen_q < OFFSET_BITS'(KEYWORD_CHARS);
			if (plen_q != LEN_MAX)
				plen_d = plen_q + 1'b1;
		end else begin
			mode_d = stl_pkg::M_IDLE;
			if (flush_has)
				plen_d = '0;
			if (is_space) begin
				tok_n     = {1'b0, flush_has};
				tok0.last = 1'b1;
			end else if (is_digit || is_letter || char_byte == "=" || char_byte == "!") begin
				tok_n     = {1'b0, flush_has};
				tok0.last = 1'b1;
				pstart_d  = offset_q;
				plen_d    = OFFSET_BITS'(1);
				if (is_digit)
					mode_d = stl_pkg::M_NUM;
				else if (is_letter) begin
					mode_d  = stl_pkg::M_WORD;
					pre_clr = 1'b1;
				end else if (char_byte == "=")
					mode_d = stl_pkg::M_EQ1;
				else
					mode_d = stl_pkg::M_BANG1;
			end else begin
				tok1.kind   = op_kind;
				tok1.start  = 16'(offset_q);
				tok1.length = 16'd1;
				tok1.last   = 1'b1;
				if (flush_has) begin
					tok_n = 2'd2;
				end else begin
					tok_n = 2'd1;
					tok0  = tok1;
				end
			end
		end
	end

	// lexer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= stl_pkg::M_IDLE;
			offset_q <= '0;
			pstart_q <= '0;
			plen_q   <= '0;
			for (int i = 0; i < KEYWORD_CHARS; i++)
				prefix_q[i] <= '0;
		end else if (fire) begin
			mode_q   <= mode_d;
			offset_q <= action ? '0 : offset_q + 1'b1;
			pstart_q <= pstart_d;
			plen_q   <= plen_d;
			if (pre_clr) begin
				for (int i = 0; i < KEYWORD_CHARS; i++)
					prefix_q[i] <= '0;
				if (!action)
					prefix_q[0] <= char_byte;
			end else if (pre_wr) begin
				prefix_q[plen_q[PIDX-1:0]] <= char_byte;
			end
		end
	end

endmodule

// File: hw/rtl/stl_back.sv
// stl_back: token queue between the lexer front and the output port
// depends on stl_pkg
module stl_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       tok_n,
	input  stl_pkg::token_t  tok0,
	input  stl_pkg::token_t  tok1,
	output logic             room,
	output logic             out_valid,
	output stl_pkg::token_t  out_tok,
	input  logic             out_stall
);

	localparam int DEPTH = 4;

	stl_pkg::token_t mem_q [DEPTH];
	logic [1:0] rd_q, wr_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign room      = cnt_q <= 3'(DEPTH - 2);
	assign out_valid = cnt_q != 3'd0;
	assign out_tok   = mem_q[rd_q];
	assign pop       = out_valid && !out_stall;

	// queue storage
	always_ff @(posedge clk) begin
		if (tok_n != 2'd0)
			mem_q[wr_q] <= tok0;
		if (tok_n == 2'd2)
			mem_q[wr_q + 2'd1] <= tok1;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + tok_n;
			rd_q  <= rd_q + 2'(pop);
			cnt_q <= cnt_q + 3'(tok_n) - 3'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		tok_n != 2'd0 |-> room) else $error("token queue overflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(DEPTH)) else $error("token queue count out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_tok))
		else $error("stalled token changed");
`endif

endmodule

// File: hw/rtl/script_token_lexer_top.sv
// script_token_lexer_top: streaming lexer, byte front end and token queue back end
// depends on stl_pkg, stl_front, stl_back
//
// channel  direction  handshake          payload
// in       in         in_valid/in_stall  action, char_byte
// out      out        out_valid/out_stall token_kind, token_start, token_length, last_of_run
//
// one byte per cycle while in_stall is low; each item's tokens (up to two) land in a four-entry queue
// the output drains one token per cycle while out_stall is low, so two-token items can slow the input
// in_stall rises when fewer than two queue entries are free
// reset clears the lexer state and empties the queue
module script_token_lexer_top #(
	parameter int OFFSET_BITS   = 16,
	parameter int KEYWORD_CHARS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  char_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic        last_of_run
);

	logic            room, fire;
	logic [1:0]      f_n, tok_n;
	stl_pkg::token_t tok0, tok1, out_tok;

	assign in_stall = !room;
	assign fire     = in_valid && room;
	assign tok_n    = fire ? f_n : 2'd0;

	stl_front #(.OFFSET_BITS(OFFSET_BITS), .KEYWORD_CHARS(KEYWORD_CHARS)) u_front (
		.clk(clk), .arst_n(arst_n), .fire(fire), .action(action),
		.char_byte(char_byte), .tok_n(f_n), .tok0(tok0), .tok1(tok1));

	stl_back u_back (
		.clk(clk), .arst_n(arst_n), .tok_n(tok_n), .tok0(tok0), .tok1(tok1),
		.room(room), .out_valid(out_valid), .out_tok(out_tok), .out_stall(out_stall));

	assign token_kind   = out_tok.kind;
	assign token_start  = out_tok.start;
	assign token_length = out_tok.length;
	assign last_of_run  = out_tok.last;

endmodule
